@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL. Each macro checks on the rising edge of clk
// and is held off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// prop must hold at every edge outside reset
`define FSPC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// cond must never be true outside reset
`define FSPC_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define FSPC_ASSERT(lbl, prop, msg)
`define FSPC_NEVER(lbl, cond, msg)

`endif

`endif

@@ rtl/fspc_pkg.sv @@
`timescale 1ns / 1ps

package fspc_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_START_CODE      = 2'd0;
    localparam logic [1:0] REG_TICK_PERIOD     = 2'd1;
    localparam logic [1:0] REG_WATCHDOG_RELOAD = 2'd2;

    // Configuration reset values
    localparam logic [7:0]  START_CODE_RESET      = 8'hAA;
    localparam logic [9:0]  TICK_PERIOD_RESET     = 10'd50;
    localparam logic [15:0] WATCHDOG_RELOAD_RESET = 16'd1000;

    // Input item kinds carried on tuser
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Number of stored payload bytes (two speed words and the enable byte)
    localparam int PAYLOAD_DEPTH = 5;
    localparam int POS_W         = $clog2(PAYLOAD_DEPTH);

    // Frame parser phases, one-hot
    typedef enum logic [3:0] {
        PH_START  = 4'b0001,
        PH_LENGTH = 4'b0010,
        PH_DATA   = 4'b0100,
        PH_CHECK  = 4'b1000
    } phase_t;

    // What the parser reports for the byte it is handed
    typedef struct packed {
        logic        good_frame;
        logic        bad_check;
        logic        load_speeds;
        logic [15:0] left_speed;
        logic [15:0] right_speed;
        logic [7:0]  enable_value;
    } parse_status_t;

    // One result item, laid out as it appears on m_tdata (left_drive lowest)
    typedef struct packed {
        logic [4:0]  pad;
        logic        checksum_error;
        logic        frame_accepted;
        logic        link_led;
        logic [7:0]  motor_enable;
        logic [15:0] right_drive;
        logic [15:0] left_drive;
    } result_t;

endpackage

@@ rtl/fspc_parser.sv @@
`timescale 1ns / 1ps

// Start / length / data / XOR checksum frame parser with the payload store
module fspc_parser (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   byte_valid,
    input  logic [7:0]             rx_byte,
    input  logic [7:0]             start_code,
    output fspc_pkg::parse_status_t status
);

    fspc_pkg::phase_t phase_reg, phase_next;
    logic [7:0] xor_reg, xor_next;
    logic [7:0] length_reg, length_next;
    logic [7:0] pos_reg, pos_next;
    logic [7:0] payload_reg [fspc_pkg::PAYLOAD_DEPTH];
    logic       payload_we;
    logic       good;
    logic       bad;

    // Next-state logic for the phase machine
    always_comb
    begin
        phase_next  = phase_reg;
        xor_next    = xor_reg;
        length_next = length_reg;
        pos_next    = pos_reg;
        payload_we  = 1'b0;
        good        = 1'b0;
        bad         = 1'b0;
        if (byte_valid)
        begin
            case (phase_reg)
                fspc_pkg::PH_START:
                begin
                    if (rx_byte == start_code)
                    begin
                        phase_next = fspc_pkg::PH_LENGTH;
                    end
                    xor_next = rx_byte;
                end
                fspc_pkg::PH_LENGTH:
                begin
                    length_next = rx_byte;
                    pos_next    = 8'd0;
                    xor_next    = xor_reg ^ rx_byte;
                    phase_next  = fspc_pkg::PH_DATA;
                end
                fspc_pkg::PH_DATA:
                begin
                    payload_we = (pos_reg < 8'(fspc_pkg::PAYLOAD_DEPTH));
                    xor_next   = xor_reg ^ rx_byte;
                    pos_next   = pos_reg + 8'd1;
                    // a zero length still consumes one data byte
                    if (pos_next >= length_reg)
                    begin
                        phase_next = fspc_pkg::PH_CHECK;
                    end
                end
                fspc_pkg::PH_CHECK:
                begin
                    good       = (rx_byte == xor_reg);
                    bad        = (rx_byte != xor_reg);
                    phase_next = fspc_pkg::PH_START;
                end
                default:
                begin
                    phase_next = fspc_pkg::PH_START;
                end
            endcase
        end
    end

    // Parser control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= fspc_pkg::PH_START;
            xor_reg    <= 8'd0;
            length_reg <= 8'd0;
            pos_reg    <= 8'd0;
        end
        else
        begin
            phase_reg  <= phase_next;
            xor_reg    <= xor_next;
            length_reg <= length_next;
            pos_reg    <= pos_next;
        end
    end

    // Payload store, only read after being written in the same frame
    always_ff @(posedge clk)
    begin
        if (payload_we)
        begin
            payload_reg[pos_reg[fspc_pkg::POS_W-1:0]] <= rx_byte;
        end
    end

    // Status toward the motor state, speed words are big endian
    always_comb
    begin
        status.good_frame   = good;
        status.bad_check    = bad;
        status.load_speeds  = good && (length_reg >= 8'(fspc_pkg::PAYLOAD_DEPTH));
        status.left_speed   = {payload_reg[0], payload_reg[1]};
        status.right_speed  = {payload_reg[2], payload_reg[3]};
        status.enable_value = payload_reg[4];
    end

endmodule

@@ rtl/framed_speed_command_parser_core.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Channel   Direction  Signals                          Contents
// s_*       in         s_tvalid s_tready s_tdata s_tuser  received byte / update tick
// m_*       out        m_tvalid m_tready m_tdata          motor words and frame flags
// cfg_*     in         cfg_valid cfg_ready cfg_index cfg_data  register writes
//
// One input item per cycle while s_tready is high; its result is registered for m_*.
// All state update for an item happens in the cycle it is accepted.
// A two-entry output buffer (output register plus skid) lets s_tready stay high while a
// result waits; s_tready drops only when both entries are full.
// cfg_ready is always high. Reset clears all control state and loads register defaults.
module framed_speed_command_parser_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tuser,   // [0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [15:0] left_drive, [31:16] right_drive,
                                   // [39:32] motor_enable, [40] link_led,
                                   // [41] frame_accepted, [42] checksum_error
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic [7:0]  start_code_reg;
    logic [9:0]  tick_period_reg;
    logic [15:0] wd_reload_reg;

    logic [15:0] left_speed_reg, left_speed_next;
    logic [15:0] right_speed_reg, right_speed_next;
    logic [7:0]  enable_reg, enable_next;
    logic [15:0] wd_reg, wd_next;
    logic        led_reg, led_next;

    logic        in_fire;
    logic        tick_fire;
    logic        wd_expired;
    fspc_pkg::parse_status_t status;
    fspc_pkg::result_t       result;

    fspc_pkg::result_t out_reg, skid_reg;
    logic              out_valid_reg, skid_valid_reg;
    logic              out_fire;

    assign s_tready  = !skid_valid_reg;
    assign in_fire   = s_tvalid && s_tready;
    assign tick_fire = in_fire && (s_tuser == fspc_pkg::OP_TICK);
    assign cfg_ready = 1'b1;

    // Configuration registers; indexes past the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_code_reg  <= fspc_pkg::START_CODE_RESET;
            tick_period_reg <= fspc_pkg::TICK_PERIOD_RESET;
            wd_reload_reg   <= fspc_pkg::WATCHDOG_RELOAD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                fspc_pkg::REG_START_CODE:      start_code_reg  <= cfg_data[7:0];
                fspc_pkg::REG_TICK_PERIOD:     tick_period_reg <= cfg_data[9:0];
                fspc_pkg::REG_WATCHDOG_RELOAD: wd_reload_reg   <= cfg_data;
                default:                       ;
            endcase
        end
    end

    fspc_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (in_fire && (s_tuser == fspc_pkg::OP_BYTE)),
        .rx_byte    (s_tdata),
        .start_code (start_code_reg),
        .status     (status)
    );

    assign wd_expired = (wd_reg < {6'd0, tick_period_reg});

    // Motor words, watchdog and link indicator
    always_comb
    begin
        left_speed_next  = left_speed_reg;
        right_speed_next = right_speed_reg;
        enable_next      = enable_reg;
        wd_next          = wd_reg;
        led_next         = led_reg;
        if (tick_fire)
        begin
            if (wd_expired)
            begin
                left_speed_next  = 16'd0;
                right_speed_next = 16'd0;
                led_next         = 1'b0;
            end
            else
            begin
                wd_next = wd_reg - {6'd0, tick_period_reg};
            end
        end
        else if (status.good_frame)
        begin
            if (status.load_speeds)
            begin
                left_speed_next  = status.left_speed;
                right_speed_next = status.right_speed;
                enable_next      = status.enable_value;
            end
            wd_next  = wd_reload_reg;
            led_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_speed_reg  <= 16'd0;
            right_speed_reg <= 16'd0;
            enable_reg      <= 8'd0;
            wd_reg          <= 16'd0;
            led_reg         <= 1'b0;
        end
        else
        begin
            left_speed_reg  <= left_speed_next;
            right_speed_reg <= right_speed_next;
            enable_reg      <= enable_next;
            wd_reg          <= wd_next;
            led_reg         <= led_next;
        end
    end

    // Result of the item accepted this cycle
    always_comb
    begin
        result.pad            = '0;
        result.checksum_error = status.bad_check;
        result.frame_accepted = status.good_frame;
        result.link_led       = led_next;
        result.motor_enable   = enable_next;
        result.right_drive    = right_speed_next;
        result.left_drive     = 16'd0 - left_speed_next;
    end

    // Output register with skid entry
    assign out_fire = out_valid_reg && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (in_fire)
        begin
            if (!out_valid_reg || out_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (out_fire)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (in_fire)
        begin
            if (!out_valid_reg || out_fire)
            begin
                out_reg <= result;
            end
            else
            begin
                skid_reg <= result;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    // Checks
    `FSPC_ASSERT(a_skid_behind_out, skid_valid_reg |-> out_valid_reg, "skid full with output empty")
    `FSPC_NEVER(a_flags_exclusive, out_valid_reg && out_reg.frame_accepted && out_reg.checksum_error, "accept and error together")
    `FSPC_ASSERT(a_good_sets_led, (out_valid_reg && out_reg.frame_accepted) |-> out_reg.link_led, "good frame without link")
    `FSPC_ASSERT(a_skid_holds, (skid_valid_reg && !m_tready) |=> (skid_valid_reg && $stable(skid_reg)), "skid entry lost")
    `FSPC_NEVER(a_tick_no_flags, tick_fire && (status.good_frame || status.bad_check), "parser flagged on a tick")

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import fspc_pkg::*;

    localparam int IDLE_LIMIT    = 5000;
    localparam int PHASE_ITEMS   = 300;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 10;

    // Index with no register behind it; writes to it must change nothing
    localparam logic [1:0] REG_NONE = 2'd3;

    typedef enum logic [1:0] {
        ENT_ITEM,
        ENT_CFG,
        ENT_DRAIN
    } entry_kind_t;

    typedef struct {
        entry_kind_t kind;
        logic        op;
        logic [7:0]  rx_val;
        logic [1:0]  idx;
        logic [15:0] wdata;
        int          gap;
    } pending_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;   // [7:0] rx_byte
    logic        s_tuser = 1'b0;   // [0] operation
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;          // [15:0] left_drive, [31:16] right_drive,
                                   // [39:32] motor_enable, [40] link_led,
                                   // [41] frame_accepted, [42] checksum_error
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = REG_START_CODE;
    logic [15:0] cfg_data = 16'd0;

    framed_speed_command_parser_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Stimulus and expectation stores
    pending_t   stim_q[$];
    result_t    motor_word_q[$];
    logic [7:0] preset_body[$];
    int         queued_items = 0;
    int         error_count = 0;
    int         result_no = 0;
    int         idle_run = 0;
    logic       calm_tx = 1'b0;
    logic       calm_rx = 1'b0;
    logic [7:0] gen_start = START_CODE_RESET;

    // Predicted block state
    phase_t      pv_phase = PH_START;
    logic [7:0]  pv_xor = 8'd0;
    logic [7:0]  pv_len = 8'd0;
    logic [7:0]  pv_pos = 8'd0;
    logic [7:0]  pv_payload[PAYLOAD_DEPTH];
    logic [15:0] pv_left = 16'd0;
    logic [15:0] pv_right = 16'd0;
    logic [7:0]  pv_enable = 8'd0;
    logic [15:0] pv_watchdog = 16'd0;
    logic        pv_led = 1'b0;
    logic [7:0]  cf_start = START_CODE_RESET;
    logic [9:0]  cf_tick = TICK_PERIOD_RESET;
    logic [15:0] cf_reload = WATCHDOG_RELOAD_RESET;

    initial begin
        forever #10 clk = ~clk;
    end

    // Apply one byte or tick to the predicted state and return the motor words
    function automatic result_t advance_drive_model(input logic op, input logic [7:0] rx);
        result_t r;
        r = '0;
        if (op == OP_TICK) begin
            if (pv_watchdog < {6'd0, cf_tick}) begin
                pv_left  = 16'd0;
                pv_right = 16'd0;
                pv_led   = 1'b0;
            end else begin
                pv_watchdog = pv_watchdog - {6'd0, cf_tick};
            end
        end else begin
            case (pv_phase)
                PH_START: begin
                    if (rx == cf_start)
                        pv_phase = PH_LENGTH;
                    pv_xor = rx;
                end
                PH_LENGTH: begin
                    pv_len   = rx;
                    pv_pos   = 8'd0;
                    pv_xor   = pv_xor ^ rx;
                    pv_phase = PH_DATA;
                end
                PH_DATA: begin
                    if (pv_pos < PAYLOAD_DEPTH)
                        pv_payload[pv_pos[2:0]] = rx;
                    pv_xor = pv_xor ^ rx;
                    pv_pos = pv_pos + 8'd1;
                    if (pv_pos >= pv_len)
                        pv_phase = PH_CHECK;
                end
                default: begin
                    if (rx == pv_xor) begin
                        r.frame_accepted = 1'b1;
                        if (pv_len >= PAYLOAD_DEPTH) begin
                            pv_left   = {pv_payload[0], pv_payload[1]};
                            pv_right  = {pv_payload[2], pv_payload[3]};
                            pv_enable = pv_payload[4];
                        end
                        pv_watchdog = cf_reload;
                        pv_led      = 1'b1;
                    end else begin
                        r.checksum_error = 1'b1;
                    end
                    pv_phase = PH_START;
                end
            endcase
        end
        r.left_drive   = 16'd0 - pv_left;
        r.right_drive  = pv_right;
        r.motor_enable = pv_enable;
        r.link_led     = pv_led;
        return r;
    endfunction

    function automatic void apply_register(input logic [1:0] idx, input logic [15:0] val);
        case (idx)
            REG_START_CODE:      cf_start = val[7:0];
            REG_TICK_PERIOD:     cf_tick = val[9:0];
            REG_WATCHDOG_RELOAD: cf_reload = val;
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        $display("tb: mismatch at result %0d: %s", result_no, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
    endtask

    // ---------------- stimulus builders ----------------
    task automatic queue_item(input logic op, input logic [7:0] rx);
        pending_t e;
        e.kind   = ENT_ITEM;
        e.op     = op;
        e.rx_val = rx;
        e.idx    = REG_START_CODE;
        e.wdata  = 16'd0;
        e.gap    = calm_tx ? 0 : $urandom_range(0, 14);
        stim_q.push_back(e);
        queued_items++;
        if ($urandom_range(0, 59) == 0)
            calm_tx = !calm_tx;
    endtask

    task automatic queue_tick();
        queue_item(OP_TICK, 8'($urandom));
    endtask

    task automatic queue_cfg(input logic [1:0] idx, input logic [15:0] val);
        pending_t e;
        e.kind   = ENT_CFG;
        e.op     = OP_BYTE;
        e.rx_val = 8'd0;
        e.idx    = idx;
        e.wdata  = val;
        e.gap    = 0;
        stim_q.push_back(e);
        if (idx == REG_START_CODE)
            gen_start = val[7:0];
    endtask

    // Hold the sender until every result is back and the block has settled
    task automatic queue_drain();
        pending_t e;
        e.kind   = ENT_DRAIN;
        e.op     = OP_BYTE;
        e.rx_val = 8'd0;
        e.idx    = REG_START_CODE;
        e.wdata  = 16'd0;
        e.gap    = 0;
        stim_q.push_back(e);
    endtask

    // Whole frame; body bytes come from preset_body first, then random.
    // Ticks may be sprinkled between bytes since they leave the parser alone.
    task automatic queue_frame(input int len, input logic good, input int tick_pct);
        logic [7:0] x;
        logic [7:0] d;
        int         n;
        x = gen_start;
        queue_item(OP_BYTE, gen_start);
        if ($urandom_range(0, 99) < tick_pct)
            queue_tick();
        queue_item(OP_BYTE, len[7:0]);
        x = x ^ len[7:0];
        n = (len == 0) ? 1 : len;
        for (int i = 0; i < n; i++) begin
            if (preset_body.size() != 0)
                d = preset_body.pop_front();
            else
                d = 8'($urandom);
            if ($urandom_range(0, 99) < tick_pct)
                queue_tick();
            queue_item(OP_BYTE, d);
            x = x ^ d;
        end
        if ($urandom_range(0, 99) < tick_pct)
            queue_tick();
        queue_item(OP_BYTE, good ? x : (x ^ 8'($urandom_range(1, 255))));
    endtask

    function automatic int pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return $urandom_range(5, 7);
        else if (r < 80)
            return $urandom_range(0, 4);
        else if (r < 99)
            return $urandom_range(8, 20);
        return $urandom_range(21, 255);
    endfunction

    // Mostly well-formed frames, plus tick bursts, noise and corrupted frames
    task automatic run_random(input int count);
        int target;
        int pick;
        int burst;
        target = queued_items + count;
        while (queued_items < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                queue_frame(pick_length(), 1'b1, 8);
            end else if (pick < 76) begin
                queue_frame(pick_length(), 1'b0, 8);
            end else if (pick < 88) begin
                burst = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 30)
                                                    : $urandom_range(1, 4);
                repeat (burst) queue_tick();
            end else begin
                repeat ($urandom_range(1, 3)) queue_item(OP_BYTE, 8'($urandom));
            end
        end
    endtask

    // ---------------- driver ----------------
    always @(posedge clk) begin
        logic     nv_s;
        logic     nv_c;
        logic     free;
        pending_t head;
        static int   wait_left = 0;
        static int   settle_left = SETTLE_CYCLES;
        static logic gap_taken = 1'b0;
        if (rst_n) begin
            free = 1'b1;
            nv_s = s_tvalid;
            nv_c = cfg_valid;
            if (s_tvalid) begin
                if (s_tready) begin
                    motor_word_q.push_back(advance_drive_model(s_tuser, s_tdata));
                    nv_s = 1'b0;
                end else begin
                    free = 1'b0;
                end
            end
            if (cfg_valid) begin
                if (cfg_ready) begin
                    apply_register(cfg_index, cfg_data);
                    nv_c = 1'b0;
                end else begin
                    free = 1'b0;
                end
            end
            if (free && stim_q.size() != 0) begin
                head = stim_q[0];
                case (head.kind)
                    ENT_DRAIN: begin
                        if (motor_word_q.size() != 0) begin
                            settle_left = SETTLE_CYCLES;
                        end else if (settle_left > 0) begin
                            settle_left--;
                        end else begin
                            void'(stim_q.pop_front());
                            settle_left = SETTLE_CYCLES;
                        end
                    end
                    ENT_CFG: begin
                        cfg_index <= head.idx;
                        cfg_data  <= head.wdata;
                        nv_c = 1'b1;
                        void'(stim_q.pop_front());
                    end
                    default: begin
                        if (!gap_taken) begin
                            gap_taken = 1'b1;
                            wait_left = head.gap;
                        end
                        if (wait_left > 0) begin
                            wait_left--;
                        end else begin
                            s_tdata <= head.rx_val;
                            s_tuser <= head.op;
                            nv_s = 1'b1;
                            gap_taken = 1'b0;
                            void'(stim_q.pop_front());
                        end
                    end
                endcase
            end
            s_tvalid  <= nv_s;
            cfg_valid <= nv_c;
        end
    end

    // ---------------- monitor ----------------
    always @(posedge clk) begin
        result_t got;
        result_t want;
        int      n;
        static int stall_left = 0;
        if (rst_n) begin
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (motor_word_q.size() == 0) begin
                    report_mismatch($sformatf("result 0x%0h with nothing expected", m_tdata));
                end else begin
                    want = motor_word_q.pop_front();
                    check_field("left_drive", got.left_drive, want.left_drive);
                    check_field("right_drive", got.right_drive, want.right_drive);
                    check_field("motor_enable", 16'(got.motor_enable), 16'(want.motor_enable));
                    check_field("link_led", 16'(got.link_led), 16'(want.link_led));
                    check_field("frame_accepted", 16'(got.frame_accepted),
                                16'(want.frame_accepted));
                    check_field("checksum_error", 16'(got.checksum_error),
                                16'(want.checksum_error));
                end
                result_no++;
                n = calm_rx ? 0 : $urandom_range(0, 14);
                if ($urandom_range(0, 79) == 0)
                    calm_rx = !calm_rx;
                if (n == 0) begin
                    m_tready <= 1'b1;
                end else begin
                    m_tready <= 1'b0;
                    stall_left = n;
                end
            end else if (!m_tready) begin
                if (stall_left <= 1)
                    m_tready <= 1'b1;
                stall_left--;
            end
        end
    end

    // Cycles without any transaction on any channel
    always @(posedge clk) begin
        if (!rst_n)
            idle_run <= 0;
        else if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_run <= 0;
        else
            idle_run <= idle_run + 1;
    end

    initial begin
        while (idle_run < IDLE_LIMIT)
            @(posedge clk);
        $display("tb: done, errors");
        $finish;
    end

    // ---------------- test sequence ----------------
    initial begin
        // directed: tick on an expired watchdog, noise while waiting
        queue_tick();
        queue_item(OP_BYTE, 8'h55);
        // full command with extreme speed bytes
        preset_body = '{8'hFF, 8'h00, 8'h80, 8'h01, 8'hFF};
        queue_frame(5, 1'b1, 0);
        queue_tick();
        // zero length still consumes one data byte
        queue_frame(0, 1'b1, 0);
        // bad checksum
        queue_frame(1, 1'b0, 0);
        // bytes past the fifth are checksummed but not stored
        preset_body = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF};
        queue_frame(6, 1'b1, 0);
        run_random(PHASE_ITEMS);

        // extremes: zero start code, tick period of one, longest watchdog
        queue_drain();
        queue_cfg(REG_START_CODE, 16'h0000);
        queue_cfg(REG_TICK_PERIOD, 16'd1);
        queue_cfg(REG_WATCHDOG_RELOAD, 16'hFFFF);
        run_random(PHASE_ITEMS);

        // opposite extremes: once a good frame reloads zero, every tick expires the watchdog
        queue_drain();
        queue_cfg(REG_START_CODE, 16'h00FF);
        queue_cfg(REG_TICK_PERIOD, 16'd1000);
        queue_cfg(REG_WATCHDOG_RELOAD, 16'd0);
        run_random(PHASE_ITEMS);

        // zero tick period and a write to the unused index
        queue_drain();
        queue_cfg(REG_START_CODE, 16'($urandom));
        queue_cfg(REG_TICK_PERIOD, 16'hFC00);
        queue_cfg(REG_WATCHDOG_RELOAD, 16'($urandom));
        queue_cfg(REG_NONE, 16'($urandom));
        run_random(PHASE_ITEMS);

        // full-width tick field with junk in the upper data bits
        queue_drain();
        queue_cfg(REG_START_CODE, 16'($urandom));
        queue_cfg(REG_TICK_PERIOD, {6'($urandom), 10'h3FF});
        queue_cfg(REG_WATCHDOG_RELOAD, 16'($urandom_range(0, 2000)));
        run_random(PHASE_ITEMS);

        // typical settings where expiry and recovery both happen
        queue_drain();
        queue_cfg(REG_START_CODE, 16'($urandom));
        queue_cfg(REG_TICK_PERIOD, 16'($urandom_range(1, 200)));
        queue_cfg(REG_WATCHDOG_RELOAD, 16'($urandom_range(0, 3000)));
        run_random(PHASE_ITEMS);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(posedge clk);
        while (stim_q.size() != 0 || s_tvalid || cfg_valid || motor_word_q.size() != 0);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
